### src/assert_macros.svh
// Assertion macros shared by the RTL of the wheel command mixer.
// Defining ASSERT_OFF turns every macro into an empty statement.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, checked at every rising clock edge out of reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, checked at every rising clock edge out of reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

// Property that must hold at every rising clock edge out of reset.
`define ASSERT_ALWAYS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("invariant check failed");

`else

`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`define ASSERT_ALWAYS(label, clk, rst, cond)

`endif

`endif

### src/ddwcm_pkg.sv
// Shared types, register indexes and constants of the wheel command mixer.
// Used by the register file, the controller, the datapath and the top level.
`timescale 1ns / 1ps

package ddwcm_pkg;

  localparam int CMD_FRAC_BITS_DEF = 12;
  localparam int UNIT_ONE = 16384;
  localparam logic [14:0] UNIT_ONE_Q = 15'd16384;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_LEFT_TRIM     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_TRIM    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEERING_GAIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VELOCITY_GAIN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PIVOT_LEVEL   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MOTOR_MIN     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MOTOR_MAX     = 3'd6;

  localparam logic [15:0] LEFT_TRIM_RST     = 16'd16384;
  localparam logic [15:0] RIGHT_TRIM_RST    = 16'd16384;
  localparam logic [15:0] STEERING_GAIN_RST = 16'd1638;
  localparam logic [15:0] VELOCITY_GAIN_RST = 16'd16384;
  localparam logic [14:0] PIVOT_LEVEL_RST   = 15'd1638;
  localparam logic [7:0]  MOTOR_MIN_RST     = 8'd130;
  localparam logic [7:0]  MOTOR_MAX_RST     = 8'd255;

  typedef struct packed {
    logic [15:0] left_trim;
    logic [15:0] right_trim;
    logic [15:0] steering_gain;
    logic [15:0] velocity_gain;
    logic [14:0] pivot_level;
    logic [7:0]  motor_min;
    logic [7:0]  motor_max;
  } cfg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_MIX,
    S_TRIM,
    S_MAP,
    S_DONE
  } state_t;

  // Strobes from the controller to the datapath.
  typedef struct packed {
    logic load_in;
    logic eval;
    logic mix;
    logic trim;
    logic map;
    logic load_out;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic repeat_hit;
  } status_t;

endpackage

### src/ddwcm_cfg_regs.sv
// Configuration register file of the wheel command mixer.
// Depends on ddwcm_pkg for the register indexes, reset values and cfg_t.
`timescale 1ns / 1ps

module ddwcm_cfg_regs (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               wr_en,
  input  logic [ddwcm_pkg::CFG_IDX_W-1:0]    wr_index,
  input  logic [ddwcm_pkg::CFG_DATA_W-1:0]   wr_data,
  output ddwcm_pkg::cfg_t                    cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.left_trim     <= ddwcm_pkg::LEFT_TRIM_RST;
      cfg.right_trim    <= ddwcm_pkg::RIGHT_TRIM_RST;
      cfg.steering_gain <= ddwcm_pkg::STEERING_GAIN_RST;
      cfg.velocity_gain <= ddwcm_pkg::VELOCITY_GAIN_RST;
      cfg.pivot_level   <= ddwcm_pkg::PIVOT_LEVEL_RST;
      cfg.motor_min     <= ddwcm_pkg::MOTOR_MIN_RST;
      cfg.motor_max     <= ddwcm_pkg::MOTOR_MAX_RST;
    end else if (wr_en) begin
      case (wr_index)
        ddwcm_pkg::REG_LEFT_TRIM:     cfg.left_trim     <= wr_data;
        ddwcm_pkg::REG_RIGHT_TRIM:    cfg.right_trim    <= wr_data;
        ddwcm_pkg::REG_STEERING_GAIN: cfg.steering_gain <= wr_data;
        ddwcm_pkg::REG_VELOCITY_GAIN: cfg.velocity_gain <= wr_data;
        ddwcm_pkg::REG_PIVOT_LEVEL:   cfg.pivot_level   <= wr_data[14:0];
        ddwcm_pkg::REG_MOTOR_MIN:     cfg.motor_min     <= wr_data[7:0];
        ddwcm_pkg::REG_MOTOR_MAX:     cfg.motor_max     <= wr_data[7:0];
        default: begin
        end
      endcase
    end
  end

endmodule

### src/ddwcm_ctrl.sv
// Sequencing state machine of the wheel command mixer.
// Depends on ddwcm_pkg for state_t, cmd_t and status_t.
`timescale 1ns / 1ps

module ddwcm_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  ddwcm_pkg::status_t   status,
  output ddwcm_pkg::cmd_t      cmd
);

  ddwcm_pkg::state_t state;
  ddwcm_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ddwcm_pkg::S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ddwcm_pkg::S_IDLE: begin
        if (in_valid) state_next = ddwcm_pkg::S_EVAL;
      end
      ddwcm_pkg::S_EVAL: begin
        // A repeated command finishes here without a result.
        state_next = status.repeat_hit ? ddwcm_pkg::S_IDLE : ddwcm_pkg::S_MIX;
      end
      ddwcm_pkg::S_MIX:  state_next = ddwcm_pkg::S_TRIM;
      ddwcm_pkg::S_TRIM: state_next = ddwcm_pkg::S_MAP;
      ddwcm_pkg::S_MAP:  state_next = ddwcm_pkg::S_DONE;
      ddwcm_pkg::S_DONE: begin
        if (!out_valid || out_ready) state_next = ddwcm_pkg::S_IDLE;
      end
      default: state_next = ddwcm_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    case (state)
      ddwcm_pkg::S_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = in_valid;
      end
      ddwcm_pkg::S_EVAL: cmd.eval = 1'b1;
      ddwcm_pkg::S_MIX:  cmd.mix  = 1'b1;
      ddwcm_pkg::S_TRIM: cmd.trim = 1'b1;
      ddwcm_pkg::S_MAP:  cmd.map  = 1'b1;
      ddwcm_pkg::S_DONE: cmd.load_out = !out_valid || out_ready;
      default: begin
      end
    endcase
  end

endmodule

### src/ddwcm_datapath.sv
// Arithmetic datapath of the wheel command mixer: command capture, repeat
// check, steering mix, trim and PWM mapping. Depends on ddwcm_pkg.
`timescale 1ns / 1ps

module ddwcm_datapath #(
  parameter int CMD_FRAC_BITS = ddwcm_pkg::CMD_FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  ddwcm_pkg::cfg_t     cfg,
  input  ddwcm_pkg::cmd_t     cmd,
  output ddwcm_pkg::status_t  status,
  input  logic signed [15:0]  speed_req,
  input  logic signed [15:0]  heading_req,
  input  logic                dir_cmd,
  input  logic                stop_req,
  output logic [7:0]          right_pwm,
  output logic                right_dir,
  output logic [7:0]          left_pwm,
  output logic                left_dir,
  output logic                stop_flag
);

  // Wide enough for the steering term plus the speed term at any fraction width.
  localparam int SUM_W = 36 - CMD_FRAC_BITS;

  logic signed [15:0] speed_in;
  logic signed [15:0] heading_in;
  logic               dir_in;
  logic               stop_in;

  logic [15:0]        last_speed_mag;
  logic [15:0]        last_heading;
  logic               last_direction;
  logic               last_stop;
  logic signed [15:0] prev_steer_heading;

  logic [15:0]        mag;
  logic               mag_zero;
  logic               head_zero;
  logic               dir_p;
  logic               stop_p;
  logic signed [17:0] head_diff;

  logic signed [34:0] steer_prod;
  logic [31:0]        speed_prod;
  logic [31:0]        speed_sh;
  logic signed [SUM_W-1:0] steer_s;
  logic signed [SUM_W-1:0] speedv_s;
  logic signed [SUM_W-1:0] left_sum;
  logic signed [SUM_W-1:0] right_sum;

  logic [14:0]        lvl_l;
  logic [14:0]        lvl_r;
  logic [30:0]        tprod_l;
  logic [30:0]        tprod_r;
  logic [14:0]        x_l;
  logic [14:0]        x_r;
  logic signed [8:0]  pwm_span;
  logic signed [24:0] mprod_l;
  logic signed [24:0] mprod_r;

  function automatic logic [14:0] clamp_unit(input logic signed [SUM_W-1:0] v);
    logic [14:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > ddwcm_pkg::UNIT_ONE) begin
      r = ddwcm_pkg::UNIT_ONE_Q;
    end else begin
      r = v[14:0];
    end
    return r;
  endfunction

  function automatic logic [14:0] sat_unit(input logic [30:0] p);
    logic [16:0] s;
    s = p[30:14];
    return (s > 17'(ddwcm_pkg::UNIT_ONE)) ? ddwcm_pkg::UNIT_ONE_Q : s[14:0];
  endfunction

  // Quotient by 2^14 rounded toward zero, low eight bits only.
  function automatic logic [7:0] span_step(input logic signed [24:0] p);
    logic [24:0] a;
    logic [10:0] s;
    a = p[24] ? 25'(-p) : 25'(p);
    s = a[24:14];
    return p[24] ? 8'(-s) : s[7:0];
  endfunction

  always_comb begin
    mag       = speed_in[15] ? 16'(-speed_in) : 16'(speed_in);
    mag_zero  = (speed_in == 16'sd0);
    head_zero = (heading_in == 16'sd0);
    dir_p     = mag_zero ? dir_in : speed_in[15];
    stop_p    = (mag_zero && head_zero) ? 1'b1 : stop_in;
    status.repeat_hit = (mag == last_speed_mag) && (heading_in == last_heading) &&
                        (dir_p == last_direction) && (stop_p == last_stop);
    head_diff = {heading_in[15], heading_in, 1'b0} -
                {{2{prev_steer_heading[15]}}, prev_steer_heading};
    steer_s   = SUM_W'(steer_prod >>> CMD_FRAC_BITS);
    speed_sh  = speed_prod >> CMD_FRAC_BITS;
    speedv_s  = $signed({1'b0, speed_sh[SUM_W-2:0]});
    left_sum  = speedv_s + steer_s;
    right_sum = speedv_s - steer_s;
    x_l       = sat_unit(tprod_l);
    x_r       = sat_unit(tprod_r);
    pwm_span  = $signed({1'b0, cfg.motor_max}) - $signed({1'b0, cfg.motor_min});
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      speed_in   <= speed_req;
      heading_in <= heading_req;
      dir_in     <= dir_cmd;
      stop_in    <= stop_req;
    end
    if (cmd.eval) begin
      steer_prod <= $signed({1'b0, cfg.steering_gain}) * head_diff;
      speed_prod <= mag * cfg.velocity_gain;
    end
    if (cmd.mix) begin
      if (!mag_zero) begin
        lvl_l <= clamp_unit(left_sum);
        lvl_r <= clamp_unit(right_sum);
      end else if (!head_zero) begin
        lvl_l <= cfg.pivot_level;
        lvl_r <= cfg.pivot_level;
      end else begin
        lvl_l <= '0;
        lvl_r <= '0;
      end
    end
    if (cmd.trim) begin
      tprod_l <= lvl_l * cfg.left_trim;
      tprod_r <= lvl_r * cfg.right_trim;
    end
    if (cmd.map) begin
      mprod_l <= $signed({1'b0, x_l}) * pwm_span;
      mprod_r <= $signed({1'b0, x_r}) * pwm_span;
    end
    if (cmd.load_out) begin
      right_pwm <= cfg.motor_min + span_step(mprod_r);
      left_pwm  <= cfg.motor_min + span_step(mprod_l);
      stop_flag <= stop_p;
      // Turning in place drives the wheels in opposite directions.
      if (mag_zero && !head_zero) begin
        left_dir  <= heading_in[15];
        right_dir <= !heading_in[15];
      end else begin
        left_dir  <= dir_p;
        right_dir <= dir_p;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_speed_mag     <= '0;
      last_heading       <= '0;
      last_direction     <= 1'b0;
      last_stop          <= 1'b0;
      prev_steer_heading <= '0;
    end else if (cmd.eval && !status.repeat_hit) begin
      last_speed_mag <= mag;
      last_heading   <= heading_in;
      last_direction <= dir_p;
      last_stop      <= stop_p;
      // The derivative memory only follows commands that actually move.
      if (!mag_zero) prev_steer_heading <= heading_in;
    end
  end

endmodule

### src/diff_drive_wheel_command_mixer.sv
// Differential-drive wheel command mixer, top level.
// Each accepted command passes the evaluate, mix, trim, map and done steps of one
// sequencer that shares one datapath; the result waits there while the output stalls.
// A new command is accepted only from idle; a repeated command ends at evaluate, unsent.
// Reset: synchronous, active high; restores register defaults and clears history.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module diff_drive_wheel_command_mixer #(
  parameter int CMD_FRAC_BITS = ddwcm_pkg::CMD_FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [15:0]               speed_req,
  input  logic signed [15:0]               heading_req,
  input  logic                             dir_cmd,
  input  logic                             stop_req,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [7:0]                       right_pwm,
  output logic                             right_dir,
  output logic [7:0]                       left_pwm,
  output logic                             left_dir,
  output logic                             stop_flag,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ddwcm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ddwcm_pkg::CFG_DATA_W-1:0] cfg_data
);

  ddwcm_pkg::cfg_t    cfg;
  ddwcm_pkg::cmd_t    cmd;
  ddwcm_pkg::status_t status;

  // Register writes always complete in the cycle they are offered.
  assign cfg_ready = 1'b1;

  ddwcm_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  ddwcm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  ddwcm_datapath #(
    .CMD_FRAC_BITS (CMD_FRAC_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .cmd         (cmd),
    .status      (status),
    .speed_req   (speed_req),
    .heading_req (heading_req),
    .dir_cmd     (dir_cmd),
    .stop_req    (stop_req),
    .right_pwm   (right_pwm),
    .right_dir   (right_dir),
    .left_pwm    (left_pwm),
    .left_dir    (left_dir),
    .stop_flag   (stop_flag)
  );

  `ASSERT_NEXT(a_busy_after_transfer, clk, rst, in_valid && in_ready, !in_ready)
  `ASSERT_IMPLIES(a_no_result_overwrite, clk, rst, cmd.load_out, !out_valid || out_ready)
  `ASSERT_ALWAYS(a_one_step_at_a_time, clk, rst, $onehot0(cmd))

endmodule

### dv/diff_drive_wheel_command_mixer_tb.sv
// Self-checking testbench for the differential-drive wheel command mixer.
// Depends on ddwcm_pkg and the top level diff_drive_wheel_command_mixer; it
// predicts each wheel drive transfer and compares it with what the block sends.
`timescale 1ns / 1ps

module diff_drive_wheel_command_mixer_tb;

  localparam int FRAC = ddwcm_pkg::CMD_FRAC_BITS_DEF;
  localparam int RUN_LIMIT = 400000;
  localparam int SETTLE = 16;
  localparam int PHASES = 9;
  localparam int ITEMS_PER_PHASE = 145;
  localparam int PLAN_ROWS = 24;
  localparam logic [ddwcm_pkg::CFG_IDX_W-1:0] REG_SPARE = 3'd7;

  typedef struct packed {
    logic [15:0] speed;
    logic [15:0] heading;
    logic        dir;
    logic        stop;
  } wheel_cmd_t;

  typedef struct packed {
    logic [7:0] right_pwm;
    logic       right_dir;
    logic [7:0] left_pwm;
    logic       left_dir;
    logic       stop;
  } wheel_drive_t;

  typedef enum logic [1:0] {ROW_PREDICT, ROW_TYPED, ROW_SILENT} row_kind_t;

  typedef struct packed {
    wheel_cmd_t   cmd;
    row_kind_t    kind;
    wheel_drive_t want;
  } plan_row_t;

  logic                                  clk = 1'b0;
  logic                                  rst = 1'b1;
  logic                                  in_valid = 1'b0;
  logic                                  in_ready;
  logic signed [15:0]                    speed_req = '0;
  logic signed [15:0]                    heading_req = '0;
  logic                                  dir_cmd = 1'b0;
  logic                                  stop_req = 1'b0;
  logic                                  out_valid;
  logic                                  out_ready = 1'b0;
  logic [7:0]                            right_pwm;
  logic                                  right_dir;
  logic [7:0]                            left_pwm;
  logic                                  left_dir;
  logic                                  stop_flag;
  logic                                  cfg_valid = 1'b0;
  logic                                  cfg_ready;
  logic [ddwcm_pkg::CFG_IDX_W-1:0]       cfg_index = '0;
  logic [ddwcm_pkg::CFG_DATA_W-1:0]      cfg_data = '0;

  diff_drive_wheel_command_mixer uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .speed_req(speed_req), .heading_req(heading_req),
    .dir_cmd(dir_cmd), .stop_req(stop_req),
    .out_valid(out_valid), .out_ready(out_ready),
    .right_pwm(right_pwm), .right_dir(right_dir),
    .left_pwm(left_pwm), .left_dir(left_dir), .stop_flag(stop_flag),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Predictor copy of the registers and the mixer history.
  longint trim_left, trim_right, steer_gain, spd_gain, pivot_lvl, pwm_floor, pwm_ceil;
  longint seen_mag, seen_heading, steer_hist;
  logic   seen_dir, seen_stop;

  wheel_drive_t drive_q[$];
  plan_row_t    plan[PLAN_ROWS];
  int send_idle_pct = 27;
  int recv_stall_pct = 61;
  int cycle_count = 0;
  int fail_count = 0;
  int cmds_sent = 0;
  int repeats_dropped = 0;
  int drives_checked = 0;
  int settings_used = 0;

  function automatic void restore_defaults();
    trim_left = ddwcm_pkg::LEFT_TRIM_RST;
    trim_right = ddwcm_pkg::RIGHT_TRIM_RST;
    steer_gain = ddwcm_pkg::STEERING_GAIN_RST;
    spd_gain = ddwcm_pkg::VELOCITY_GAIN_RST;
    pivot_lvl = ddwcm_pkg::PIVOT_LEVEL_RST;
    pwm_floor = ddwcm_pkg::MOTOR_MIN_RST;
    pwm_ceil = ddwcm_pkg::MOTOR_MAX_RST;
    seen_mag = 0;
    seen_heading = 0;
    seen_dir = 1'b0;
    seen_stop = 1'b0;
    steer_hist = 0;
  endfunction

  function automatic void apply_reg(input logic [ddwcm_pkg::CFG_IDX_W-1:0] idx,
                                    input logic [15:0] data);
    case (idx)
      ddwcm_pkg::REG_LEFT_TRIM:     trim_left = data;
      ddwcm_pkg::REG_RIGHT_TRIM:    trim_right = data;
      ddwcm_pkg::REG_STEERING_GAIN: steer_gain = data;
      ddwcm_pkg::REG_VELOCITY_GAIN: spd_gain = data;
      ddwcm_pkg::REG_PIVOT_LEVEL:   pivot_lvl = data[14:0];
      ddwcm_pkg::REG_MOTOR_MIN:     pwm_floor = data[7:0];
      ddwcm_pkg::REG_MOTOR_MAX:     pwm_ceil = data[7:0];
      default: ;
    endcase
  endfunction

  function automatic logic [7:0] pwm_code(input longint level, input longint trim);
    longint x, prod, q;
    x = (level * trim) >>> 14;
    if (x > ddwcm_pkg::UNIT_ONE) x = ddwcm_pkg::UNIT_ONE;
    prod = x * (pwm_ceil - pwm_floor);
    // The step from motor_min rounds toward zero, so a downward map stays in range.
    q = (prod >= 0) ? (prod >>> 14) : -((-prod) >>> 14);
    return 8'(pwm_floor + q);
  endfunction

  function automatic longint clamp_unit(input longint x);
    if (x < 0) return 0;
    if (x > ddwcm_pkg::UNIT_ONE) return ddwcm_pkg::UNIT_ONE;
    return x;
  endfunction

  // Returns 1 when the command produces a wheel drive transfer.
  function automatic bit mix_wheels(input wheel_cmd_t c, output wheel_drive_t r);
    longint spd, hdg, mag, steer, speedv, lv, rv;
    logic d, s, dl, dr;
    spd = $signed(c.speed);
    hdg = $signed(c.heading);
    d = (spd > 0) ? 1'b0 : (spd < 0) ? 1'b1 : c.dir;
    mag = (spd < 0) ? -spd : spd;
    s = (mag == 0 && hdg == 0) ? 1'b1 : c.stop;
    r = '0;
    if (mag == seen_mag && longint'(c.heading) == seen_heading && d == seen_dir &&
        s == seen_stop)
      return 1'b0;
    seen_mag = mag;
    seen_heading = c.heading;
    seen_dir = d;
    seen_stop = s;
    dl = d;
    dr = d;
    lv = 0;
    rv = 0;
    if (mag == 0 && hdg != 0) begin
      dl = (hdg < 0);
      dr = (hdg > 0);
      lv = pivot_lvl;
      rv = pivot_lvl;
    end
    if (mag > 0) begin
      steer = (steer_gain * (2 * hdg - steer_hist)) >>> FRAC;
      speedv = (mag * spd_gain) >>> FRAC;
      steer_hist = hdg;
      lv = clamp_unit(speedv + steer);
      rv = clamp_unit(speedv - steer);
    end
    r.right_pwm = pwm_code(rv, trim_right);
    r.right_dir = dr;
    r.left_pwm = pwm_code(lv, trim_left);
    r.left_dir = dl;
    r.stop = s;
    return 1'b1;
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    wheel_drive_t got, want;
    cycle_count++;
    if (!rst && out_valid && out_ready) begin
      got = '{right_pwm, right_dir, left_pwm, left_dir, stop_flag};
      if (drive_q.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected wheel drive transfer, expected none, got %h", $time, got);
      end else begin
        want = drive_q.pop_front();
        drives_checked++;
        check_field("right_pwm", want.right_pwm, got.right_pwm);
        check_field("right_dir", want.right_dir, got.right_dir);
        check_field("left_pwm", want.left_pwm, got.left_pwm);
        check_field("left_dir", want.left_dir, got.left_dir);
        check_field("stop_flag", want.stop, got.stop);
      end
    end
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  initial begin
    wait (cycle_count >= RUN_LIMIT);
    $display("FAILURE");
    $finish;
  end

  task automatic write_reg(input logic [ddwcm_pkg::CFG_IDX_W-1:0] idx,
                           input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, data);
  endtask

  task automatic push_cmd(input wheel_cmd_t c, output bit emit, output wheel_drive_t drive);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    speed_req <= c.speed;
    heading_req <= c.heading;
    dir_cmd <= c.dir;
    stop_req <= c.stop;
    do @(posedge clk); while (!in_ready);
    cmds_sent++;
    emit = mix_wheels(c, drive);
    if (!emit) repeats_dropped++;
  endtask

  // A dropped repeat leaves nothing to wait for, so allow the pipeline to empty too.
  task automatic drain();
    in_valid <= 1'b0;
    while (drive_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic configure(input int ph);
    logic [15:0] vals [0:6];
    vals[ddwcm_pkg::REG_LEFT_TRIM] = 16'($urandom_range(8192, 24576));
    vals[ddwcm_pkg::REG_RIGHT_TRIM] = 16'($urandom_range(8192, 24576));
    vals[ddwcm_pkg::REG_STEERING_GAIN] = 16'($urandom_range(0, 8192));
    vals[ddwcm_pkg::REG_VELOCITY_GAIN] = 16'($urandom_range(4096, 32768));
    vals[ddwcm_pkg::REG_PIVOT_LEVEL] = 16'($urandom_range(0, 20000));
    vals[ddwcm_pkg::REG_MOTOR_MIN] = 16'($urandom);
    vals[ddwcm_pkg::REG_MOTOR_MAX] = 16'($urandom);
    case (ph)
      0: begin
        vals[ddwcm_pkg::REG_LEFT_TRIM] = ddwcm_pkg::LEFT_TRIM_RST;
        vals[ddwcm_pkg::REG_RIGHT_TRIM] = ddwcm_pkg::RIGHT_TRIM_RST;
        vals[ddwcm_pkg::REG_STEERING_GAIN] = ddwcm_pkg::STEERING_GAIN_RST;
        vals[ddwcm_pkg::REG_VELOCITY_GAIN] = ddwcm_pkg::VELOCITY_GAIN_RST;
        vals[ddwcm_pkg::REG_PIVOT_LEVEL] = 16'(ddwcm_pkg::PIVOT_LEVEL_RST);
        vals[ddwcm_pkg::REG_MOTOR_MIN] = 16'(ddwcm_pkg::MOTOR_MIN_RST);
        vals[ddwcm_pkg::REG_MOTOR_MAX] = 16'(ddwcm_pkg::MOTOR_MAX_RST);
      end
      1: begin
        foreach (vals[i]) vals[i] = 16'hFFFF;
        vals[ddwcm_pkg::REG_MOTOR_MIN] = 16'h0000;
        vals[ddwcm_pkg::REG_MOTOR_MAX] = 16'h00FF;
      end
      2: foreach (vals[i]) vals[i] = 16'h0000;
      3: begin
        vals[ddwcm_pkg::REG_MOTOR_MIN] = 16'h00FF;
        vals[ddwcm_pkg::REG_MOTOR_MAX] = 16'h0000;
      end
      4: vals[ddwcm_pkg::REG_PIVOT_LEVEL] = 16'(ddwcm_pkg::UNIT_ONE);
      default: ;
    endcase
    for (int i = ddwcm_pkg::REG_LEFT_TRIM; i <= ddwcm_pkg::REG_MOTOR_MAX; i++)
      write_reg(i[ddwcm_pkg::CFG_IDX_W-1:0], vals[i]);
    // A write to the unused index must change nothing.
    if (ph == 0) write_reg(REG_SPARE, 16'($urandom));
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  function automatic wheel_cmd_t random_cmd(input wheel_cmd_t last);
    wheel_cmd_t c;
    int pick;
    logic [15:0] edges [5];
    edges = '{16'h7FFF, 16'h8000, 16'h0000, 16'h0001, 16'hFFFF};
    pick = $urandom_range(99);
    c.speed = 16'($urandom);
    c.heading = 16'($urandom);
    c.dir = 1'($urandom);
    c.stop = 1'($urandom);
    if (pick < 12) begin
      c = last;
    end else if (pick < 27) begin
      c.speed = 16'h0000;
      if ($urandom_range(3) == 0) c.heading = 16'h0000;
    end else if (pick < 37) begin
      c.speed = edges[$urandom_range(4)];
      c.heading = edges[$urandom_range(4)];
    end else if (pick < 90) begin
      // Moderate commands keep the mix out of saturation most of the time.
      c.speed = 16'($urandom_range(0, 16383)) - 16'd8192;
      c.heading = 16'($urandom_range(0, 8191)) - 16'd4096;
    end
    return c;
  endfunction

  initial begin
    wheel_cmd_t   last_cmd;
    wheel_drive_t drive;
    bit           emit;
    restore_defaults();
    plan[0]  = '{'{16'h0000, 16'h0000, 1'b0, 1'b0}, ROW_TYPED,
                 '{8'd130, 1'b0, 8'd130, 1'b0, 1'b1}};
    plan[1]  = '{'{16'h0000, 16'h0000, 1'b0, 1'b0}, ROW_SILENT, '0};
    plan[2]  = '{'{16'h0000, 16'h0000, 1'b1, 1'b0}, ROW_TYPED,
                 '{8'd130, 1'b1, 8'd130, 1'b1, 1'b1}};
    plan[3]  = '{'{16'h0000, 16'h0064, 1'b0, 1'b0}, ROW_PREDICT, '0};
    plan[4]  = '{'{16'h0000, 16'h0064, 1'b0, 1'b0}, ROW_SILENT, '0};
    plan[5]  = '{'{16'h0000, 16'hFF9C, 1'b1, 1'b0}, ROW_PREDICT, '0};
    plan[6]  = '{'{16'h0000, 16'h8000, 1'b0, 1'b1}, ROW_PREDICT, '0};
    plan[7]  = '{'{16'h0000, 16'h7FFF, 1'b1, 1'b1}, ROW_PREDICT, '0};
    plan[8]  = '{'{16'h7FFF, 16'h0000, 1'b0, 1'b0}, ROW_TYPED,
                 '{8'd255, 1'b0, 8'd255, 1'b0, 1'b0}};
    plan[9]  = '{'{16'h8000, 16'h0000, 1'b0, 1'b0}, ROW_TYPED,
                 '{8'd255, 1'b1, 8'd255, 1'b1, 1'b0}};
    plan[10] = '{'{16'h8000, 16'h0000, 1'b1, 1'b0}, ROW_SILENT, '0};
    plan[11] = '{'{16'h1000, 16'h1000, 1'b0, 1'b0}, ROW_PREDICT, '0};
    plan[12] = '{'{16'h1000, 16'h1000, 1'b0, 1'b0}, ROW_SILENT, '0};
    plan[13] = '{'{16'h1000, 16'h8000, 1'b0, 1'b0}, ROW_PREDICT, '0};
    plan[14] = '{'{16'h1000, 16'h7FFF, 1'b0, 1'b0}, ROW_PREDICT, '0};
    plan[15] = '{'{16'h0001, 16'h0001, 1'b0, 1'b1}, ROW_PREDICT, '0};
    plan[16] = '{'{16'hFFFF, 16'hFFFF, 1'b1, 1'b0}, ROW_PREDICT, '0};
    plan[17] = '{'{16'h0800, 16'h0000, 1'b0, 1'b0}, ROW_PREDICT, '0};
    plan[18] = '{'{16'h0800, 16'h0000, 1'b0, 1'b0}, ROW_SILENT, '0};
    plan[19] = '{'{16'h0000, 16'h0000, 1'b0, 1'b1}, ROW_TYPED,
                 '{8'd130, 1'b0, 8'd130, 1'b0, 1'b1}};
    plan[20] = '{'{16'h0000, 16'h0000, 1'b0, 1'b0}, ROW_SILENT, '0};
    plan[21] = '{'{16'h5555, 16'hAAAA, 1'b0, 1'b0}, ROW_PREDICT, '0};
    plan[22] = '{'{16'hAAAA, 16'h5555, 1'b1, 1'b1}, ROW_PREDICT, '0};
    plan[23] = '{'{16'h0000, 16'h0001, 1'b1, 1'b0}, ROW_PREDICT, '0};

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed commands run on the register values left by reset.
    foreach (plan[i]) begin
      push_cmd(plan[i].cmd, emit, drive);
      case (plan[i].kind)
        ROW_TYPED:   drive_q.push_back(plan[i].want);
        ROW_PREDICT: if (emit) drive_q.push_back(drive);
        default: ;
      endcase
      last_cmd = plan[i].cmd;
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      case (ph / 3)
        0: begin send_idle_pct = 27; recv_stall_pct = 61; end
        1: begin send_idle_pct = 61; recv_stall_pct = 27; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      configure(ph);
      repeat (ITEMS_PER_PHASE) begin
        last_cmd = random_cmd(last_cmd);
        push_cmd(last_cmd, emit, drive);
        if (emit) drive_q.push_back(drive);
      end
    end
    drain();

    $display("Sent %0d speed and heading commands under %0d register settings.",
             cmds_sent, settings_used);
    $display("Checked %0d wheel drive transfers; %0d repeated commands were dropped.",
             drives_checked, repeats_dropped);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
